[hdl/cmexp_pkg.sv]
// Shared constants and sequencer state type for the per-character modexp decrypter.
`default_nettype none

package cmexp_pkg;

  // Width of the configuration registers and of the exponent scan
  localparam int unsigned CFG_W = 16;
  localparam int unsigned EXP_W = 16;
  localparam int unsigned EBIT_W = $clog2(EXP_W);

  // Default datapath width of the modulus
  localparam int unsigned MOD_WIDTH_DEFAULT = 16;

  // Character offset applied before and after exponentiation
  localparam logic [7:0] CHAR_OFFSET = 8'd96;

  // Reset values of the registers
  localparam logic [CFG_W-1:0] MODULUS_RESET  = 16'hFFFF;
  localparam logic [CFG_W-1:0] EXPONENT_RESET = 16'd1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_SQ_MUL,
    S_SQ_RED,
    S_MP_MUL,
    S_MP_RED,
    S_OUT
  } cmexp_state_t;

endpackage

`default_nettype wire

[hdl/char_modexp_decrypt.sv]
// Top level: per-character modular exponentiation decrypter with a shared multiply/reduce unit.
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// input    | in        | in_valid / in_ready  | code [7:0] signed ciphertext character
// output   | out       | out_valid / out_ready| plain [7:0] decrypted character
// config   | in        | cfg_valid / cfg_ready| cfg_index [0:0], cfg_data [15:0]
//
// After acceptance the block reduces the base mod n, then scans all EXP_W exponent bits from the
// top: each bit squares the accumulator and reduces, and each set bit also multiplies by the base
// and reduces; the result reaches the output register as the block returns to idle. Every
// modular reduction runs through the shared bit-serial remainder unit. A zero exponent skips the
// arithmetic and goes straight to output. Synchronous reset returns to idle, empties the output
// register and loads modulus 65535 and exponent 1. The next item is accepted while a
// finished result still waits in the output register; the block holds in_ready low while busy.

module char_modexp_decrypt
  import cmexp_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = MOD_WIDTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // ciphertext items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [7:0]    code,
  // plaintext items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                plain,
  // register writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned PROD_W = 2 * MOD_WIDTH;
  localparam int unsigned CNT_W  = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  cmexp_state_t state, state_next;

  // Configuration registers
  logic [CFG_W-1:0] modulus;
  logic [CFG_W-1:0] exponent;

  // Datapath registers
  logic [MOD_WIDTH-1:0] acc;     // running magnitude of the power
  logic [MOD_WIDTH-1:0] m;       // base magnitude reduced mod n
  logic [PROD_W-1:0]    prod;    // product being reduced, MSB first
  logic [MOD_WIDTH-1:0] rem;     // partial remainder
  logic [CNT_W-1:0]     cnt;     // reduction bit counter
  logic [EBIT_W-1:0]    ebit;    // exponent bit being scanned
  logic                 neg;     // result sign: negative base with odd exponent

  // Effective modulus: low MOD_WIDTH bits, zero treated as one
  logic [MOD_WIDTH+CFG_W-1:0] mod_ext;
  logic [MOD_WIDTH-1:0]       mod_lo;
  logic [MOD_WIDTH-1:0]       n_eff;

  assign mod_ext = {{MOD_WIDTH{1'b0}}, modulus};
  assign mod_lo  = mod_ext[MOD_WIDTH-1:0];
  assign n_eff   = (mod_lo == '0) ? MOD_WIDTH'(1) : mod_lo;

  // Offset character and its magnitude (range -224..31)
  logic [8:0] c9;
  logic [8:0] c9_neg;
  logic [7:0] cmag;

  assign c9     = {code[7], code} - {1'b0, CHAR_OFFSET};
  assign c9_neg = 9'd0 - c9;
  assign cmag   = c9[8] ? c9_neg[7:0] : c9[7:0];

  // Shared multiplier: square the accumulator or multiply by the base
  logic [MOD_WIDTH-1:0] mul_b;
  logic [PROD_W-1:0]    prod_mul;

  assign mul_b    = (state == S_MP_MUL) ? m : acc;
  assign prod_mul = {{MOD_WIDTH{1'b0}}, acc} * {{MOD_WIDTH{1'b0}}, mul_b};

  // Shared restoring remainder step: shift in one product bit, subtract n if it fits
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   diff;
  logic                 fits;
  logic [MOD_WIDTH-1:0] rem_next;
  logic                 red_last;

  assign trial    = {rem, prod[PROD_W-1]};
  assign diff     = trial - {1'b0, n_eff};
  assign fits     = trial >= {1'b0, n_eff};
  assign rem_next = fits ? diff[MOD_WIDTH-1:0] : trial[MOD_WIDTH-1:0];
  assign red_last = (cnt == CNT_LAST);

  // Output register loads once the slot is empty or being drained
  logic out_load;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // zero exponent: the power is one, skip the arithmetic
          state_next = (exponent == '0) ? S_OUT : S_BASE;
        end
      end
      S_BASE: begin
        if (red_last) state_next = S_SQ_MUL;
      end
      S_SQ_MUL: state_next = S_SQ_RED;
      S_SQ_RED: begin
        if (red_last) begin
          if (exponent[ebit]) state_next = S_MP_MUL;
          else if (ebit == '0) state_next = S_OUT;
          else state_next = S_SQ_MUL;
        end
      end
      S_MP_MUL: state_next = S_MP_RED;
      S_MP_RED: begin
        if (red_last) state_next = (ebit == '0) ? S_OUT : S_SQ_MUL;
      end
      S_OUT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= MODULUS_RESET;
      exponent  <= EXPONENT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODULUS:  modulus  <= cfg_data;
          REG_EXPONENT: exponent <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath: left-to-right square-and-multiply on the magnitude
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          prod <= {{(PROD_W-8){1'b0}}, cmag};
          rem  <= '0;
          cnt  <= '0;
          acc  <= MOD_WIDTH'(1);
          ebit <= EBIT_W'(EXP_W - 1);
          neg  <= c9[8] & exponent[0];
        end
      end
      S_BASE, S_SQ_RED, S_MP_RED: begin
        prod <= {prod[PROD_W-2:0], 1'b0};
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
        if (red_last) begin
          if (state == S_BASE) begin
            m <= rem_next;
          end else begin
            acc <= rem_next;
            // advance to the next exponent bit unless a multiply is still due
            if (ebit != '0 && (state == S_MP_RED || !exponent[ebit])) begin
              ebit <= ebit - 1'b1;
            end
          end
        end
      end
      S_SQ_MUL, S_MP_MUL: begin
        prod <= prod_mul;
        rem  <= '0;
        cnt  <= '0;
      end
      S_OUT: begin
        // low 8 bits of signed result plus offset
        if (out_load) plain <= neg ? (CHAR_OFFSET - acc[7:0]) : (CHAR_OFFSET + acc[7:0]);
      end
      default: ;
    endcase
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_zero_exp_shortcut: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && exponent == '0) |=> (state == S_OUT))
    else $error("zero exponent did not skip the arithmetic");

  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (state == S_BASE || state == S_SQ_RED || state == S_MP_RED) |-> (rem < n_eff))
    else $error("partial remainder reached the modulus");

  a_base_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_MP_MUL) |-> (m < n_eff))
    else $error("base not reduced below the modulus");

endmodule

`default_nettype wire
